### rtl/determinant_orbital_create_destroy_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef DETERMINANT_ORBITAL_CREATE_DESTROY_ASSERT_SVH
`define DETERMINANT_ORBITAL_CREATE_DESTROY_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define DOC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define DOC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/doc_pkg.sv
`default_nettype none

package doc_pkg;

  // Sizing of the two orbital lists.
  localparam int MAX_PER_SPIN = 32;
  localparam int MAX_BASIS    = 255;
  localparam int ORB_W        = 8;
  localparam int ADDR_W       = (MAX_PER_SPIN > 1) ? $clog2(MAX_PER_SPIN) : 1;
  localparam int CNT_W        = $clog2(MAX_PER_SPIN + 1);
  localparam int MEM_DEPTH    = 2 ** (ADDR_W + 1);

  // Item and configuration widths.
  localparam int ORBITAL_W = 9;
  localparam int CFG_W     = 8;
  localparam int REG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ELECTRON_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASIS_SIZE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPIN_EXCESS    = 2'd2;

  // Operation codes.
  localparam logic FUNC_CREATE  = 1'b0;
  localparam logic FUNC_DESTROY = 1'b1;

  // Phase values.
  localparam logic signed [1:0] PHASE_ZERO = 2'sb00;
  localparam logic signed [1:0] PHASE_POS  = 2'sb01;
  localparam logic signed [1:0] PHASE_NEG  = 2'sb11;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // List memory write source.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ITEM,
    WR_CARRY,
    WR_BACK
  } wr_sel_t;

  // Count update.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    walk_start;
    logic    advance;
    logic    take_carry;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;
    logic full;
    logic empty;
    logic destroy;
    logic at_end;
    logic hit;
    logic below;
    logic odd;
  } stat_t;

endpackage

`default_nettype wire

### rtl/doc_if.sv
`default_nettype none

// Request channel: one create or destroy operation per transfer.
interface doc_in_if;
  import doc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic signed [ORBITAL_W-1:0] orbital;

  modport source (output valid, output func, output orbital, input ready);
  modport sink (input valid, input func, input orbital, output ready);
endinterface

// Result channel: status and phase of one operation per transfer.
interface doc_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [1:0] phase;

  modport source (output valid, output status, output phase, input ready);
  modport sink (input valid, input status, input phase, output ready);
endinterface

`default_nettype wire

### rtl/doc_ctrl.sv
`default_nettype none

module doc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic signed [1:0]      phase,
  input  wire doc_pkg::stat_t    stat,
  output doc_pkg::cmd_t          cmd
);
  import doc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_SHIFT,
    S_REPORT
  } state_t;

  state_t            state, state_next;
  status_t           pend_status, pend_status_next;
  logic signed [1:0] pend_phase, pend_phase_next;
  logic              out_free;
  logic signed [1:0] ins_phase;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  // Sign of an insertion at the current position: even position is positive.
  assign ins_phase = stat.odd ? PHASE_NEG : PHASE_POS;

  // Next state and commands.
  always_comb begin
    cmd              = '0;
    cmd.wr_sel       = WR_NONE;
    cmd.cnt_op       = CNT_HOLD;
    state_next       = state;
    pend_status_next = pend_status;
    pend_phase_next  = pend_phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        pend_status_next = ST_OK;
        pend_phase_next  = PHASE_ZERO;
        if (stat.invalid) begin
          pend_status_next = ST_INVALID;
          state_next       = S_REPORT;
        end else if (!stat.destroy && stat.full) begin
          pend_status_next = ST_FULL;
          state_next       = S_REPORT;
        end else if (stat.destroy && stat.empty) begin
          pend_status_next = ST_EMPTY;
          state_next       = S_REPORT;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.destroy) begin
          // Create: look for an equal entry, the first smaller entry or the end of the list.
          if (stat.at_end) begin
            cmd.wr_sel      = WR_ITEM;
            cmd.cnt_op      = CNT_INC;
            pend_phase_next = ins_phase;
            state_next      = S_REPORT;
          end else if (stat.hit) begin
            state_next = S_REPORT;
          end else if (stat.below) begin
            cmd.wr_sel      = WR_ITEM;
            cmd.take_carry  = 1'b1;
            cmd.advance     = 1'b1;
            pend_phase_next = ins_phase;
            state_next      = S_SHIFT;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          // Destroy: look for an equal entry.
          if (stat.at_end) begin
            state_next = S_REPORT;
          end else if (stat.hit) begin
            cmd.advance     = 1'b1;
            pend_phase_next = PHASE_POS;
            state_next      = S_SHIFT;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        if (!stat.destroy) begin
          // Create: push the displaced entries up by one place.
          cmd.wr_sel = WR_CARRY;
          if (stat.at_end) begin
            cmd.cnt_op = CNT_INC;
            state_next = S_REPORT;
          end else begin
            cmd.take_carry = 1'b1;
            cmd.advance    = 1'b1;
          end
        end else begin
          // Destroy: pull the following entries down by one place.
          if (stat.at_end) begin
            cmd.cnt_op = CNT_DEC;
            state_next = S_REPORT;
          end else begin
            cmd.wr_sel  = WR_BACK;
            cmd.advance = 1'b1;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, pending result and the output register.
  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
    pend_phase  <= pend_phase_next;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_REPORT && out_free) begin
        out_valid <= 1'b1;
        status    <= pend_status;
        phase     <= pend_phase;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/doc_dpath.sv
`default_nettype none

module doc_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [doc_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [doc_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                 func,
  input  wire logic signed [doc_pkg::ORBITAL_W-1:0] orbital,
  input  wire doc_pkg::cmd_t                        cmd,
  output doc_pkg::stat_t                            stat
);
  import doc_pkg::*;

  // Configuration registers.
  logic [6:0]                  electron_count;
  logic [7:0]                  basis_size;
  logic signed [7:0]           spin_excess;

  // Latched item.
  logic                        item_func;
  logic signed [ORBITAL_W-1:0] item_orb;

  // List state.
  logic [ORB_W-1:0]            list_mem [MEM_DEPTH];
  logic [CNT_W-1:0]            alpha_count;
  logic [CNT_W-1:0]            beta_count;
  logic [ORB_W-1:0]            rdata;
  logic [ORB_W-1:0]            carry;
  logic [CNT_W-1:0]            ptr;

  logic                        is_alpha;
  logic [ORBITAL_W-1:0]        mag;
  logic [ORB_W-1:0]            mag_key;
  logic signed [9:0]           cap_sum;
  logic [7:0]                  cap_half;
  logic [7:0]                  capacity;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            ptr_inc;
  logic [CNT_W-1:0]            ptr_dec;
  logic [ADDR_W-1:0]           rd_idx;
  logic [ADDR_W-1:0]           wr_idx;
  logic [ORB_W-1:0]            wr_data;

  // Orbital decode: sign picks the list, magnitude is the key.
  assign is_alpha = !item_orb[ORBITAL_W-1] && (item_orb != '0);
  assign mag      = item_orb[ORBITAL_W-1] ? ORBITAL_W'(-item_orb) : ORBITAL_W'(item_orb);
  assign mag_key  = mag[ORB_W-1:0];
  assign count    = is_alpha ? alpha_count : beta_count;

  // Per-spin capacity: half the electron sum, clamped to the list size.
  assign cap_sum  = is_alpha
                  ? ($signed({3'b000, electron_count}) + 10'(spin_excess))
                  : ($signed({3'b000, electron_count}) - 10'(spin_excess));
  assign cap_half = cap_sum[8:1];
  always_comb begin
    if (cap_sum[9] || cap_sum == '0) begin
      capacity = '0;
    end else if (cap_half > 8'(MAX_PER_SPIN)) begin
      capacity = 8'(MAX_PER_SPIN);
    end else begin
      capacity = cap_half;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.invalid = (item_orb == '0) || (mag > {1'b0, basis_size})
                || (32'(mag) > MAX_BASIS);
    stat.full    = 8'(count) >= capacity;
    stat.empty   = (count == '0);
    stat.destroy = (item_func == FUNC_DESTROY);
    stat.at_end  = (ptr == count);
    stat.hit     = (rdata == mag_key);
    stat.below   = (rdata < mag_key);
    stat.odd     = ptr[0];
  end

  // Walk addresses: read one ahead of the current position.
  assign ptr_inc = ptr + CNT_W'(1);
  assign ptr_dec = ptr - CNT_W'(1);
  assign rd_idx  = cmd.walk_start ? '0 : ptr_inc[ADDR_W-1:0];
  assign wr_idx  = (cmd.wr_sel == WR_BACK) ? ptr_dec[ADDR_W-1:0] : ptr[ADDR_W-1:0];

  always_comb begin
    case (cmd.wr_sel)
      WR_ITEM:  wr_data = mag_key;
      WR_CARRY: wr_data = carry;
      default:  wr_data = rdata;
    endcase
  end

  // List memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      list_mem[{!is_alpha, wr_idx}] <= wr_data;
    end
    rdata <= list_mem[{!is_alpha, rd_idx}];
  end

  // Item, walk position and carried entry.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func <= func;
      item_orb  <= orbital;
    end
    if (cmd.walk_start) begin
      ptr <= '0;
    end else if (cmd.advance) begin
      ptr <= ptr_inc;
    end
    if (cmd.take_carry) begin
      carry <= rdata;
    end
  end

  // Configuration registers and list counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      electron_count <= '0;
      basis_size     <= 8'd255;
      spin_excess    <= '0;
      alpha_count    <= '0;
      beta_count     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ELECTRON_COUNT: electron_count <= cfg_data[6:0];
          REG_BASIS_SIZE:     basis_size     <= cfg_data;
          REG_SPIN_EXCESS:    spin_excess    <= $signed(cfg_data);
          default: ;
        endcase
      end
      case (cmd.cnt_op)
        CNT_INC: begin
          if (is_alpha) alpha_count <= alpha_count + CNT_W'(1);
          else          beta_count  <= beta_count + CNT_W'(1);
        end
        CNT_DEC: begin
          if (is_alpha) alpha_count <= alpha_count - CNT_W'(1);
          else          beta_count  <= beta_count - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/determinant_orbital_create_destroy.sv
// Occupied-orbital lists of one determinant with create and destroy operations.
// Each transfer on item asks to create (func 0) or destroy (func 1) one orbital;
// a positive orbital addresses the alpha list, a negative one the beta list.
// Every item gives exactly one transfer on result: status 0 ok, 1 invalid
// orbital, 2 list full, 3 list empty, and phase +1/-1 for a create (-1 when the
// number of larger occupied orbitals is odd), +1 for a successful destroy, else 0.
// Items are handled one at a time. A rejected item passes from its transfer
// through the evaluate and report states to its result; an item that walks a
// list steps through its entries in turn, as the list memory is read and
// rewritten one entry per cycle.
// The next item is taken while a result still waits in the output register.
// Lists are empty after reset; configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while the block is idle, as the block does not enforce this.
`default_nettype none

module determinant_orbital_create_destroy (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [doc_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [doc_pkg::CFG_W-1:0]     cfg_data,
  doc_in_if.sink                             item,
  doc_out_if.source                          result
);
  import doc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  doc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (result.status),
    .phase     (result.phase),
    .stat      (stat),
    .cmd       (cmd)
  );

  doc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (item.func),
    .orbital   (item.orbital),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

### rtl/doc_checker.sv
`default_nettype none

`include "determinant_orbital_create_destroy_assert.svh"

module doc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        status,
  input wire logic signed [1:0] phase
);
  import doc_pkg::*;

  // A stalled result keeps its value.
  `DOC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(phase), "result changed while stalled")

  // Any error status carries a zero phase.
  `DOC_ASSERT_NOW(a_err_phase, out_valid && status != ST_OK, phase == PHASE_ZERO, "nonzero phase with error status")

  // Phase is always one of -1, 0 or +1.
  `DOC_ASSERT_NOW(a_phase_range, out_valid, phase != 2'sb10, "phase out of range")

  // Items are taken one at a time: no transfer right after a transfer.
  `DOC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while another is at work")

endmodule

bind determinant_orbital_create_destroy doc_checker u_doc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .status    (result.status),
  .phase     (result.phase)
);

`default_nettype wire
